// ===== src/psh_pkg.sv =====
// Shared types and constants for the pot smoother with publish hysteresis.
// No dependencies.
package psh_pkg;

  localparam int LEVEL_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int SHIFT_W    = 4;
  localparam int HYST_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd3;
  localparam logic [HYST_W-1:0]  HYST_RESET  = 16'd64;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_SHIFT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUBLISH_HYSTERESIS = 1'd1;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // One pending publish: level to square, and its origin
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               boot;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/psh_front.sv =====
// Front end: config registers, sample acceptance, smoothing state and publish decision.
// Depends on psh_pkg.
module psh_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [psh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psh_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             func,
  input  logic [psh_pkg::LEVEL_W-1:0]      sample,
  input  logic                             sink_ready,
  input  psh_pkg::q_status_t               q_stat,
  output logic                             push,
  output psh_pkg::q_entry_t                push_entry
);

  localparam int SB = SAMPLE_BITS;

  logic [psh_pkg::SHIFT_W-1:0] smoothing_shift;
  logic [psh_pkg::HYST_W-1:0]  publish_hysteresis;
  logic                        seeded;
  logic [SB-1:0]               level;
  logic [SB-1:0]               published_level;

  logic [SB-1:0] s;
  logic [SB-1:0] diff;
  logic [SB-1:0] step_raw;
  logic [SB-1:0] step;
  logic [SB-1:0] level_next;
  logic [SB-1:0] pub_base;
  logic [SB-1:0] published_level_next;
  logic [SB-1:0] distance;
  logic          emit;
  logic          accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    s        = sample[SB-1:0];
    diff     = (s > level) ? (s - level) : (level - s);
    step_raw = diff >> smoothing_shift;
    step     = (step_raw == '0) ? SB'(1) : step_raw;

    if (!seeded) begin
      level_next = s;
    end else if (s > level) begin
      level_next = level + step;
    end else if (s < level) begin
      level_next = level - step;
    end else begin
      level_next = level;
    end

    // seeding sample becomes the published level
    pub_base = seeded ? published_level : s;
    distance = (level_next >= pub_base) ? (level_next - pub_base)
                                        : (pub_base - level_next);
    emit     = func || (psh_pkg::HYST_W'(distance) >= publish_hysteresis);

    published_level_next = pub_base;
    if (!func && emit && sink_ready) begin
      published_level_next = level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_shift    <= psh_pkg::SHIFT_RESET;
      publish_hysteresis <= psh_pkg::HYST_RESET;
      seeded             <= 1'b0;
      level              <= '0;
      published_level    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          psh_pkg::REG_SMOOTHING_SHIFT:
            smoothing_shift <= cfg_data[psh_pkg::SHIFT_W-1:0];
          psh_pkg::REG_PUBLISH_HYSTERESIS:
            publish_hysteresis <= cfg_data[psh_pkg::HYST_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        seeded          <= 1'b1;
        level           <= level_next;
        published_level <= published_level_next;
      end
    end
  end

  assign push             = accept && emit;
  assign push_entry.level = psh_pkg::LEVEL_W'(level_next);
  assign push_entry.boot  = func;

endmodule

// ===== src/psh_queue.sv =====
// Small register FIFO between the front end and the gain unit.
// Depends on psh_pkg.
module psh_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  psh_pkg::q_entry_t  push_entry,
  input  logic               pop,
  output psh_pkg::q_entry_t  head,
  output psh_pkg::q_status_t q_stat
);

  psh_pkg::q_entry_t           mem [psh_pkg::QDEPTH];
  logic [psh_pkg::QPTR_W-1:0]  wr_ptr;
  logic [psh_pkg::QPTR_W-1:0]  rd_ptr;
  logic [psh_pkg::QCNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (count == psh_pkg::QCNT_W'(psh_pkg::QDEPTH));
  assign q_stat.empty = (count == '0);

endmodule

// ===== src/psh_back.sv =====
// Back end: pipelined square-law gain (square, scale, reciprocal estimate, fix-up).
// Depends on psh_pkg.
module psh_back #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  psh_pkg::q_status_t            q_stat,
  input  psh_pkg::q_entry_t             head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psh_pkg::GAIN_W-1:0]    gain,
  output logic [psh_pkg::LEVEL_W-1:0]   smoothed_level,
  output logic                          from_boot
);

  localparam int SB = SAMPLE_BITS;
  localparam int GW = psh_pkg::GAIN_W;
  localparam int PW = 2 * SB;       // level squared
  localparam int NW = PW + GW;      // level squared times 65535
  localparam int HW = 32;           // numerator bits seen by the estimate
  localparam int SH = NW - HW;
  localparam int RW = GW + 2;       // reciprocal is just above 2^16
  localparam int EW = HW + RW;
  localparam int MW = PW + 2;       // remainder stays below three divisors
  // square, scale, estimate, back-multiply, remainder, fix-up
  localparam int NS = 6;

  localparam longint unsigned FS    = (64'd1 << SB) - 64'd1;
  localparam longint unsigned DIV_L = FS * FS;
  // floor(2^NW / FS^2); the estimate lands at most two below the quotient
  localparam longint unsigned RCP_L = (64'd1 << NW) / DIV_L;

  localparam logic [RW-1:0] RCP  = RW'(RCP_L);
  localparam logic [MW-1:0] DIV1 = MW'(DIV_L);
  localparam logic [MW-1:0] DIV2 = MW'(64'd2 * DIV_L);

  logic          vld [NS];
  logic [SB-1:0] lvl [NS];
  logic          bt  [NS];
  logic [PW-1:0] sq;
  logic [NW-1:0] num;
  logic [GW-1:0] qe2;
  logic [MW-1:0] nlo2;
  logic [GW-1:0] qe3;
  logic [MW-1:0] nlo3;
  logic [MW-1:0] qd3;
  logic [GW-1:0] qe4;
  logic [MW-1:0] rem4;
  logic [GW-1:0] quo;
  logic [HW-1:0] num_hi;
  logic [EW-1:0] est;
  logic [1:0]    fix;
  logic          adv;

  // whole pipe holds while the result is not taken
  assign adv = !vld[NS-1] || out_ready;
  assign pop = adv && !q_stat.empty;

  assign num_hi = num[NW-1:SH];
  assign est    = EW'(num_hi) * EW'(RCP);
  assign fix    = (rem4 >= DIV2) ? 2'd2 : ((rem4 >= DIV1) ? 2'd1 : 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= !q_stat.empty;
      for (int i = 1; i < NS; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lvl[0] <= head.level[SB-1:0];
      bt[0]  <= head.boot;
      for (int i = 1; i < NS; i++) begin
        lvl[i] <= lvl[i-1];
        bt[i]  <= bt[i-1];
      end
      sq   <= PW'(head.level[SB-1:0]) * PW'(head.level[SB-1:0]);
      // times 65535
      num  <= (NW'(sq) << GW) - NW'(sq);
      qe2  <= est[HW +: GW];
      nlo2 <= num[MW-1:0];
      qe3  <= qe2;
      nlo3 <= nlo2;
      // low bits are enough: true remainder is below 3 * FS^2
      qd3  <= MW'(qe2) * DIV1;
      qe4  <= qe3;
      rem4 <= nlo3 - qd3;
      quo  <= qe4 + GW'(fix);
    end
  end

  assign out_valid      = vld[NS-1];
  assign gain           = quo;
  assign smoothed_level = psh_pkg::LEVEL_W'(lvl[NS-1]);
  assign from_boot      = bt[NS-1];

endmodule

// ===== src/pot_smoother_with_publish_hysteresis_core.sv =====
// Top level of the pot smoother with square-law gain and publish hysteresis.
// Depends on psh_pkg, psh_front, psh_queue, psh_back.
//
// Usage: one sample transaction is taken per clock while the four-entry queue
// between the smoothing front end and the gain unit has room, so the block
// sustains one item per cycle when the result side keeps up. The front end
// updates the smoothed level and decides in the accepting cycle whether a
// gain is published; only publishing transactions enter the queue. The gain
// unit is a six-stage pipeline (square, scale by 65535, reciprocal estimate
// of the quotient by the full-scale square, back-multiply, remainder, fix-up
// of at most two), whatever SAMPLE_BITS is. The pipeline stalls as a whole
// while out_valid is held without out_ready; the queue absorbs the front end
// meanwhile. Configuration writes land at once.
module pot_smoother_with_publish_hysteresis_core #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [psh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psh_pkg::CFG_DATA_W-1:0]  cfg_data,
  // sample channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic [psh_pkg::LEVEL_W-1:0]     sample,
  input  logic                            sink_ready,
  // gain channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [psh_pkg::GAIN_W-1:0]      gain,
  output logic [psh_pkg::LEVEL_W-1:0]     smoothed_level,
  output logic                            from_boot
);

  logic               q_push;
  logic               q_pop;
  psh_pkg::q_entry_t  q_in;
  psh_pkg::q_entry_t  q_head;
  psh_pkg::q_status_t q_stat;

  // Smoothing state and publish decision
  psh_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .sample     (sample),
    .sink_ready (sink_ready),
    .q_stat     (q_stat),
    .push       (q_push),
    .push_entry (q_in)
  );

  // Decouples the front end from gain-unit stalls
  psh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .q_stat     (q_stat)
  );

  // Square-law gain pipeline, last stage is the output register
  psh_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_stat         (q_stat),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .gain           (gain),
    .smoothed_level (smoothed_level),
    .from_boot      (from_boot)
  );

  // A boot capture always publishes
  a_boot_publishes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func) |-> q_push)
    else $error("boot capture did not publish");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue overflow");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue underflow");

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== dv/pot_smoother_with_publish_hysteresis_core_test.sv =====
// Self-checking testbench for pot_smoother_with_publish_hysteresis_core.
// Depends on psh_pkg and the core RTL; holds its own predictor of the smoothed
// level, the publish hysteresis and the square-law gain.
module pot_smoother_with_publish_hysteresis_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS = 16;
  localparam logic [63:0] FULL_SCALE = (64'd1 << SAMPLE_BITS) - 64'd1;
  // Settle time after the last expected result: gain pipeline is six deep
  localparam int DRAIN_CYCLES = 40;

  localparam logic FUNC_RUNTIME = 1'b0;
  localparam logic FUNC_BOOT    = 1'b1;

  // One sample transaction as offered to the block
  typedef struct {
    logic                        boot;
    logic [psh_pkg::LEVEL_W-1:0] smp;
    logic                        rdy;
  } knob_xact_t;

  // One gain transaction as the block should publish it
  typedef struct {
    logic [psh_pkg::GAIN_W-1:0]  gain;
    logic [psh_pkg::LEVEL_W-1:0] lvl;
    logic                        boot;
  } gain_xact_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [psh_pkg::CFG_IDX_W-1:0]  cfg_index = psh_pkg::REG_SMOOTHING_SHIFT;
  logic [psh_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           func = FUNC_RUNTIME;
  logic [psh_pkg::LEVEL_W-1:0]    sample = '0;
  logic                           sink_ready = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [psh_pkg::GAIN_W-1:0]     gain;
  logic [psh_pkg::LEVEL_W-1:0]    smoothed_level;
  logic                           from_boot;

  pot_smoother_with_publish_hysteresis_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .sample         (sample),
    .sink_ready     (sink_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .gain           (gain),
    .smoothed_level (smoothed_level),
    .from_boot      (from_boot)
  );

  // Samples waiting for the driver, gains waiting for the monitor
  knob_xact_t knob_pending[$];
  gain_xact_t gain_expect[$];

  int sent_total  = 0;   // samples queued for the driver
  int taken_total = 0;   // samples the block accepted
  int err_count   = 0;
  int src_gap     = 0;
  int sink_gap    = 0;
  bit quiet       = 1'b0; // no idling on either side
  int knob        = 32768; // wandering pot position for random walks

  // Predictor state: configuration copy and smoother state
  logic [psh_pkg::SHIFT_W-1:0] m_shift = psh_pkg::SHIFT_RESET;
  logic [psh_pkg::HYST_W-1:0]  m_hyst  = psh_pkg::HYST_RESET;
  bit                          m_seeded = 1'b0;
  logic [psh_pkg::LEVEL_W-1:0] m_level = '0;
  logic [psh_pkg::LEVEL_W-1:0] m_pub   = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // Step the smoothed level with one accepted sample and queue the gain it
  // publishes, if any.
  task automatic predict_publish(input logic boot,
                                 input logic [psh_pkg::LEVEL_W-1:0] raw,
                                 input logic rdy);
    logic [psh_pkg::LEVEL_W-1:0] smp;
    logic [psh_pkg::LEVEL_W-1:0] step;
    logic [psh_pkg::LEVEL_W-1:0] distance;
    logic [63:0]                 num;
    gain_xact_t                  g;
    smp = raw & FULL_SCALE[psh_pkg::LEVEL_W-1:0];
    if (!m_seeded) begin
      // first sample seeds both the level and the published level
      m_seeded = 1'b1;
      m_level  = smp;
      m_pub    = smp;
    end else if (smp > m_level) begin
      step = (smp - m_level) >> m_shift;
      if (step == '0) step = psh_pkg::LEVEL_W'(1);
      m_level = m_level + step;
    end else if (smp < m_level) begin
      step = (m_level - smp) >> m_shift;
      if (step == '0) step = psh_pkg::LEVEL_W'(1);
      m_level = m_level - step;
    end
    if (!boot) begin
      distance = (m_level >= m_pub) ? m_level - m_pub : m_pub - m_level;
      if (distance < m_hyst) return;
      // published level only follows when the sink took it
      if (rdy) m_pub = m_level;
    end
    num    = 64'(m_level);
    num    = num * 64'(m_level) * 64'd65535;
    g.gain = psh_pkg::GAIN_W'(num / (FULL_SCALE * FULL_SCALE));
    g.lvl  = m_level;
    g.boot = boot;
    gain_expect.push_back(g);
  endtask

  // Driver: offers queued samples, with random idle bursts between them.
  always @(posedge clk) begin : drv
    knob_xact_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_publish(func, sample, sink_ready);
        taken_total++;
      end
      // payload may only change once the current transaction is gone
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else if (knob_pending.size() != 0) begin
          nxt = knob_pending.pop_front();
          in_valid   <= 1'b1;
          func       <= nxt.boot;
          sample     <= nxt.smp;
          sink_ready <= nxt.rdy;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each gain transaction, stalls the result side at random.
  always @(posedge clk) begin : mon
    gain_xact_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (gain_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected gain %0d level %0d boot %0b",
                                    gain, smoothed_level, from_boot));
        end else begin
          want = gain_expect.pop_front();
          if (gain !== want.gain)
            report_mismatch($sformatf("gain %0d, expected %0d (level %0d)",
                                      gain, want.gain, want.lvl));
          if (smoothed_level !== want.lvl)
            report_mismatch($sformatf("smoothed_level %0d, expected %0d",
                                      smoothed_level, want.lvl));
          if (from_boot !== want.boot)
            report_mismatch($sformatf("from_boot %0b, expected %0b",
                                      from_boot, want.boot));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_sample(input logic boot, input logic [psh_pkg::LEVEL_W-1:0] smp,
                              input logic rdy);
    knob_xact_t x;
    x.boot = boot;
    x.smp  = smp;
    x.rdy  = rdy;
    knob_pending.push_back(x);
    sent_total++;
  endtask

  // Block is idle once every sample is in and every gain is out
  task automatic wait_drained();
    while (taken_total != sent_total || gain_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [psh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psh_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Shift register only keeps its low bits; junk above them must be dropped
  task automatic set_regs(input logic [psh_pkg::SHIFT_W-1:0] shift,
                          input logic [psh_pkg::HYST_W-1:0] hyst);
    logic [psh_pkg::CFG_DATA_W-1:0] shift_word;
    shift_word = psh_pkg::CFG_DATA_W'($urandom);
    shift_word[psh_pkg::SHIFT_W-1:0] = shift;
    write_reg(psh_pkg::REG_SMOOTHING_SHIFT, shift_word);
    write_reg(psh_pkg::REG_PUBLISH_HYSTERESIS, hyst);
    m_shift = shift;
    m_hyst  = hyst;
  endtask

  // Mostly a pot being turned (random walk), plus jumps, rails, bit flips
  // and raw noise; a few boot captures mixed in.
  task automatic queue_random(input int n);
    logic                        boot;
    logic [psh_pkg::LEVEL_W-1:0] smp;
    int                          pick;
    for (int i = 0; i < n; i++) begin
      boot = ($urandom_range(0, 9) == 0) ? FUNC_BOOT : FUNC_RUNTIME;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        knob = knob + int'($urandom_range(0, 2048)) - 1024;
        if (knob < 0) knob = 0;
        if (knob > 65535) knob = 65535;
        smp = psh_pkg::LEVEL_W'(knob);
      end else if (pick < 75) begin
        smp = psh_pkg::LEVEL_W'($urandom);
      end else if (pick < 85) begin
        smp = ($urandom_range(0, 1) == 1) ? '1 : '0;
      end else if (pick < 95) begin
        knob = int'($urandom_range(0, 65535));
        smp  = psh_pkg::LEVEL_W'(knob);
      end else begin
        smp = psh_pkg::LEVEL_W'(knob ^ (1 << $urandom_range(0, psh_pkg::LEVEL_W - 1)));
      end
      queue_sample(boot, smp, $urandom_range(0, 3) != 0);
    end
  endtask

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: runtime seeding sample stays quiet at hysteresis 64,
    // then boot captures at both rails and runtime with sink not ready.
    queue_sample(FUNC_RUNTIME, 16'h8000, 1'b1);
    queue_sample(FUNC_BOOT,    16'hFFFF, 1'b0);
    queue_sample(FUNC_BOOT,    16'h0000, 1'b1);
    queue_sample(FUNC_RUNTIME, 16'hFFFF, 1'b0);
    queue_sample(FUNC_RUNTIME, 16'hFFFF, 1'b1);
    queue_sample(FUNC_RUNTIME, 16'h0000, 1'b1);
    wait_drained();

    // No smoothing, zero hysteresis: every runtime sample publishes,
    // including a repeat at distance zero and the full-scale level.
    set_regs(4'd0, 16'd0);
    queue_sample(FUNC_RUNTIME, 16'h1234, 1'b1);
    queue_sample(FUNC_RUNTIME, 16'h1234, 1'b0);
    queue_sample(FUNC_RUNTIME, 16'hFFFF, 1'b0);
    queue_sample(FUNC_RUNTIME, 16'h0000, 1'b1);
    queue_sample(FUNC_BOOT,    16'hA5A5, 1'b0);
    queue_sample(FUNC_RUNTIME, 16'h5A5A, 1'b1);
    wait_drained();

    // Heaviest smoothing, maximum hysteresis: steps of one, only boots emit
    set_regs(4'd15, 16'hFFFF);
    queue_sample(FUNC_RUNTIME, 16'h0000, 1'b1);
    queue_sample(FUNC_BOOT,    16'hFFFF, 1'b0);
    repeat (4) queue_sample(FUNC_RUNTIME, 16'hFFFF, 1'b1);
    queue_sample(FUNC_BOOT,    16'h0001, 1'b1);
    wait_drained();

    set_regs(4'd1, 16'd1);
    queue_sample(FUNC_RUNTIME, 16'h0001, 1'b1);
    queue_sample(FUNC_RUNTIME, 16'hFFFE, 1'b0);
    queue_sample(FUNC_RUNTIME, 16'h7FFF, 1'b1);
    wait_drained();

    // Random phases, each under its own settings
    set_regs(psh_pkg::SHIFT_RESET, psh_pkg::HYST_RESET);
    queue_random(100);
    wait_drained();

    set_regs(psh_pkg::SHIFT_W'($urandom_range(0, 15)),
             psh_pkg::HYST_W'($urandom_range(0, 255)));
    queue_random(100);
    wait_drained();

    set_regs(4'd0, 16'd1);
    queue_random(100);
    wait_drained();

    set_regs(4'd15, 16'd0);
    queue_random(100);
    wait_drained();

    set_regs(psh_pkg::SHIFT_W'($urandom_range(0, 15)), psh_pkg::HYST_W'($urandom));
    queue_random(80);
    wait_drained();

    set_regs(4'd2, 16'd16);
    queue_random(100);
    wait_drained();

    // Last stretch at full rate on both sides
    quiet = 1'b1;
    set_regs(psh_pkg::SHIFT_W'($urandom_range(1, 6)), 16'd32);
    queue_random(70);
    wait_drained();

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
